/* design/bpm_pkg.sv */
// Shared types, codes and reset values of the polled bus master.
package bpm_pkg;

    // Default number of nodes on the bus, polled as addresses 1..NODE_COUNT.
    localparam int NODE_COUNT_DEF = 16;

    // Stream and configuration port widths.
    localparam int TDATA_IN_W    = 64;
    localparam int TUSER_IN_W    = 3;
    localparam int TDATA_OUT_W   = 64;
    localparam int OUT_DATA_BITS = 61;
    localparam int TUSER_OUT_W   = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 20;

    // Register values after reset.
    localparam logic        RST_SELF_TEST_EN   = 1'b0;
    localparam logic [7:0]  RST_SELF_TEST_NODE = 8'd1;
    localparam logic [19:0] RST_TIMEOUT_US     = 20'd6000;
    localparam logic [19:0] RST_BACKOFF_US     = 20'd2000;
    localparam logic [19:0] RST_IDLE_US        = 20'd4000;
    localparam logic [19:0] RST_SELF_TEST_US   = 20'd1000;
    localparam logic [3:0]  RST_MAX_RETRY      = 4'd3;

    // First message id after reset; id zero is never used.
    localparam logic [15:0] MSG_ID_FIRST = 16'd1;

    // Input operation codes. The fourth code is ignored.
    typedef enum logic [1:0] {
        OP_TIME_STEP = 2'd0,
        OP_FRAME     = 2'd1,
        OP_CRC_ERROR = 2'd2
    } op_t;

    // Event codes reported with each result.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_POLL_SENT = 3'd1,
        EV_ACK       = 3'd2,
        EV_IGNORED   = 3'd3,
        EV_RETRY     = 3'd4,
        EV_TIMEOUT   = 3'd5,
        EV_CRC_ERROR = 3'd6
    } ev_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SELF_TEST_EN   = 3'd0,
        CFG_SELF_TEST_NODE = 3'd1,
        CFG_TIMEOUT_US     = 3'd2,
        CFG_BACKOFF_US     = 3'd3,
        CFG_IDLE_US        = 3'd4,
        CFG_SELF_TEST_US   = 3'd5,
        CFG_MAX_RETRY      = 3'd6
    } cfg_index_t;

    // Current configuration as seen by the core.
    typedef struct packed {
        logic        self_test_enable;
        logic [7:0]  self_test_node;
        logic [19:0] ack_wait_us;
        logic [19:0] resend_delay_us;
        logic [19:0] idle_poll_us;
        logic [19:0] self_test_interval_us;
        logic [3:0]  max_retry;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_us;
        logic [7:0]  rx_node;
        logic [15:0] rx_msg_id;
        logic        rx_is_ack;
        logic [7:0]  rx_len;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        handled;
        ev_kind_t    event_kind;
        logic [7:0]  event_node;
        logic [15:0] event_msg_id;
        logic [31:0] round_trip_us;
        logic [4:0]  online_count;
    } result_t;

endpackage

/* design/bpm_cfg_regs.sv */
// Configuration register file of the polled bus master.
module bpm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bpm_pkg::cfg_t                    cfg
);
    import bpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; an index past the list changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SELF_TEST_EN:   cfg_next.self_test_enable      = cfg_data[0];
                CFG_SELF_TEST_NODE: cfg_next.self_test_node        = cfg_data[7:0];
                CFG_TIMEOUT_US:     cfg_next.ack_wait_us           = cfg_data;
                CFG_BACKOFF_US:     cfg_next.resend_delay_us       = cfg_data;
                CFG_IDLE_US:        cfg_next.idle_poll_us          = cfg_data;
                CFG_SELF_TEST_US:   cfg_next.self_test_interval_us = cfg_data;
                CFG_MAX_RETRY:      cfg_next.max_retry             = cfg_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.self_test_enable      <= RST_SELF_TEST_EN;
            cfg_reg.self_test_node        <= RST_SELF_TEST_NODE;
            cfg_reg.ack_wait_us           <= RST_TIMEOUT_US;
            cfg_reg.resend_delay_us       <= RST_BACKOFF_US;
            cfg_reg.idle_poll_us          <= RST_IDLE_US;
            cfg_reg.self_test_interval_us <= RST_SELF_TEST_US;
            cfg_reg.max_retry             <= RST_MAX_RETRY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/bpm_in_stage.sv */
// Input register of the polled bus master: holds one accepted transaction.
module bpm_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpm_pkg::TDATA_IN_W-1:0]  s_tdata,
    input  logic [bpm_pkg::TUSER_IN_W-1:0]  s_tuser,
    input  logic                            advance,
    output logic                            item_valid,
    output bpm_pkg::in_item_t               item
);
    import bpm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    in_item_t item_in;
    logic     take;

    // The register frees up in the same cycle that the core consumes it.
    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Unpack the stream fields.
    always_comb
    begin
        item_in.operation = s_tuser[1:0];
        item_in.rx_is_ack = s_tuser[2];
        item_in.now_us    = s_tdata[31:0];
        item_in.rx_node   = s_tdata[39:32];
        item_in.rx_msg_id = s_tdata[55:40];
        item_in.rx_len    = s_tdata[63:56];
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

endmodule

/* design/bpm_core.sv */
// Poll scheduler, acknowledgement matching and retry logic with the node table.
module bpm_core #(
    parameter int NODE_COUNT = bpm_pkg::NODE_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bpm_pkg::cfg_t      cfg,
    input  logic               step,
    input  bpm_pkg::in_item_t  item,
    output bpm_pkg::result_t   result
);
    import bpm_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam logic [7:0]       NODE_MAX = 8'(NODE_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODE_COUNT - 1);

    // Node table.
    logic       online_reg  [NODE_COUNT];
    logic [3:0] retries_reg [NODE_COUNT];

    // Scheduler state.
    logic [CNT_W-1:0] total_reg,       total_next;
    logic [IDX_W-1:0] rr_index_reg,    rr_index_next;
    logic [7:0]       pending_node_reg, pending_node_next;
    logic             awaiting_reg,    awaiting_next;
    logic             resend_reg,      resend_next;
    logic [15:0]      outstanding_reg, outstanding_next;
    logic [15:0]      msg_counter_reg, msg_counter_next;
    logic [31:0]      request_time_reg, request_time_next;
    logic [31:0]      next_poll_reg,   next_poll_next;

    // Table write for the pending node.
    logic             tbl_we;
    logic             tbl_online_wr;
    logic [3:0]       tbl_retries_wr;

    logic [7:0]       pend_off;
    logic             pend_in_range;
    logic [IDX_W-1:0] pend_idx;
    logic             cur_online;
    logic [3:0]       cur_retries;
    logic [3:0]       retries_inc;

    logic [19:0]      gap;
    logic [31:0]      since_req;
    logic [31:0]      poll_diff;
    logic [31:0]      now_plus_gap;
    logic [31:0]      now_plus_backoff;
    logic [31:0]      now_plus_timeout;
    logic [15:0]      msg_counter_inc;
    logic [7:0]       rr_node;
    logic             ack_match;
    logic [CNT_W+4:0] total_ext;

    // Both an acknowledgement and a timeout only ever touch the pending node.
    assign pend_off      = pending_node_reg - 8'd1;
    assign pend_in_range = (pending_node_reg != 8'd0) && (pending_node_reg <= NODE_MAX);
    assign pend_idx      = pend_off[IDX_W-1:0];
    assign cur_online    = pend_in_range ? online_reg[pend_idx] : 1'b0;
    assign cur_retries   = pend_in_range ? retries_reg[pend_idx] : 4'd0;
    assign retries_inc   = cur_retries + 4'd1;

    // Time arithmetic, all modulo 2^32.
    assign gap              = cfg.self_test_enable ? cfg.self_test_interval_us
                                                   : cfg.idle_poll_us;
    assign since_req        = item.now_us - request_time_reg;
    assign poll_diff        = item.now_us - next_poll_reg;
    assign now_plus_gap     = item.now_us + {12'd0, gap};
    assign now_plus_backoff = item.now_us + {12'd0, cfg.resend_delay_us};
    assign now_plus_timeout = item.now_us + {12'd0, cfg.ack_wait_us};

    // Message ids skip zero.
    assign msg_counter_inc = (msg_counter_reg == 16'hFFFF) ? MSG_ID_FIRST
                                                           : msg_counter_reg + 16'd1;
    assign rr_node         = 8'(rr_index_reg) + 8'd1;

    assign ack_match = item.rx_is_ack && (item.rx_len == 8'd0) && awaiting_reg &&
                       (item.rx_node == pending_node_reg) &&
                       (item.rx_msg_id == outstanding_reg) && pend_in_range;

    // Next state and result for the item in the input register.
    always_comb
    begin
        total_next        = total_reg;
        rr_index_next     = rr_index_reg;
        pending_node_next = pending_node_reg;
        awaiting_next     = awaiting_reg;
        resend_next       = resend_reg;
        outstanding_next  = outstanding_reg;
        msg_counter_next  = msg_counter_reg;
        request_time_next = request_time_reg;
        next_poll_next    = next_poll_reg;
        tbl_we            = 1'b0;
        tbl_online_wr     = cur_online;
        tbl_retries_wr    = cur_retries;

        result.handled       = 1'b0;
        result.event_kind    = EV_NONE;
        result.event_node    = 8'd0;
        result.event_msg_id  = 16'd0;
        result.round_trip_us = 32'd0;

        case (item.operation)
            OP_CRC_ERROR:
            begin
                result.handled    = 1'b1;
                result.event_kind = EV_CRC_ERROR;
            end
            OP_FRAME:
            begin
                result.handled      = 1'b1;
                result.event_node   = item.rx_node;
                result.event_msg_id = item.rx_msg_id;
                if (ack_match)
                begin
                    awaiting_next     = 1'b0;
                    resend_next       = 1'b0;
                    pending_node_next = 8'd0;
                    request_time_next = 32'd0;
                    next_poll_next    = now_plus_gap;
                    tbl_we            = 1'b1;
                    tbl_online_wr     = 1'b1;
                    tbl_retries_wr    = 4'd0;
                    if (!cur_online)
                        total_next = total_reg + CNT_W'(1);
                    result.event_kind    = EV_ACK;
                    result.round_trip_us = since_req;
                end
                else
                begin
                    result.event_kind = EV_IGNORED;
                end
            end
            OP_TIME_STEP:
            begin
                if (awaiting_reg)
                begin
                    if (since_req > {12'd0, cfg.ack_wait_us})
                    begin
                        awaiting_next     = 1'b0;
                        request_time_next = 32'd0;
                        if (!pend_in_range)
                        begin
                            // Stray pending address: drop the poll silently.
                            resend_next      = 1'b0;
                            outstanding_next = 16'd0;
                            next_poll_next   = now_plus_gap;
                        end
                        else
                        begin
                            result.handled      = 1'b1;
                            result.event_node   = pending_node_reg;
                            result.event_msg_id = outstanding_reg;
                            tbl_we              = 1'b1;
                            if (retries_inc < cfg.max_retry)
                            begin
                                tbl_retries_wr    = retries_inc;
                                resend_next       = 1'b1;
                                next_poll_next    = now_plus_backoff;
                                result.event_kind = EV_RETRY;
                            end
                            else
                            begin
                                // Retry limit reached: the node goes offline.
                                tbl_online_wr     = 1'b0;
                                tbl_retries_wr    = 4'd0;
                                if (cur_online)
                                    total_next = total_reg - CNT_W'(1);
                                pending_node_next = 8'd0;
                                resend_next       = 1'b0;
                                outstanding_next  = 16'd0;
                                next_poll_next    = now_plus_gap;
                                result.event_kind = EV_TIMEOUT;
                            end
                        end
                    end
                end
                else if (!poll_diff[31])
                begin
                    // Poll is due: resend the last poll or start a new one.
                    result.handled    = 1'b1;
                    result.event_kind = EV_POLL_SENT;
                    if (resend_reg)
                    begin
                        resend_next         = 1'b0;
                        result.event_node   = pending_node_reg;
                        result.event_msg_id = outstanding_reg;
                    end
                    else
                    begin
                        pending_node_next   = cfg.self_test_enable ? cfg.self_test_node
                                                                   : rr_node;
                        result.event_node   = pending_node_next;
                        result.event_msg_id = msg_counter_reg;
                        outstanding_next    = msg_counter_reg;
                        msg_counter_next    = msg_counter_inc;
                        if (!cfg.self_test_enable)
                            rr_index_next = (rr_index_reg == IDX_LAST) ? '0
                                                                       : rr_index_reg + IDX_W'(1);
                    end
                    awaiting_next     = 1'b1;
                    request_time_next = item.now_us;
                    next_poll_next    = now_plus_timeout;
                end
            end
            default:
            begin
                result.handled = 1'b0;
            end
        endcase

        // The online count reported is the one after this item.
        total_ext           = {5'd0, total_next};
        result.online_count = total_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= '0;
            rr_index_reg     <= '0;
            pending_node_reg <= 8'd0;
            awaiting_reg     <= 1'b0;
            resend_reg       <= 1'b0;
            outstanding_reg  <= 16'd0;
            msg_counter_reg  <= MSG_ID_FIRST;
            request_time_reg <= 32'd0;
            next_poll_reg    <= {12'd0, RST_IDLE_US};
        end
        else if (step)
        begin
            total_reg        <= total_next;
            rr_index_reg     <= rr_index_next;
            pending_node_reg <= pending_node_next;
            awaiting_reg     <= awaiting_next;
            resend_reg       <= resend_next;
            outstanding_reg  <= outstanding_next;
            msg_counter_reg  <= msg_counter_next;
            request_time_reg <= request_time_next;
            next_poll_reg    <= next_poll_next;
        end
    end

    // Node table update, one entry per item at most.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                online_reg[i]  <= 1'b0;
                retries_reg[i] <= 4'd0;
            end
        end
        else if (step && tbl_we)
        begin
            online_reg[pend_idx]  <= tbl_online_wr;
            retries_reg[pend_idx] <= tbl_retries_wr;
        end
    end

endmodule

/* design/bpm_out_stage.sv */
// Result register of the polled bus master, driving the output stream.
module bpm_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  bpm_pkg::result_t                 result,
    output logic                             advance,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpm_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic [bpm_pkg::TUSER_OUT_W-1:0]  m_tuser
);
    import bpm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new result may enter while the current one is being taken.
    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    // Pack the result fields, lowest field first.
    assign m_tdata = {{(TDATA_OUT_W - OUT_DATA_BITS){1'b0}},
                      result_reg.online_count, result_reg.round_trip_us,
                      result_reg.event_msg_id, result_reg.event_node};
    assign m_tuser = {result_reg.event_kind, result_reg.handled};

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

endmodule

/* design/bus_poll_master_retry.sv */
// Top level of the polled bus master with timeout and retry.
//
//  Channel  Direction  Handshake           Contents
//  s_*      in         s_tvalid/s_tready   bus event or time step
//  m_*      out        m_tvalid/m_tready   one result per input transaction
//  cfg_*    in         cfg_valid/cfg_ready register index and write data
//
// Each transaction waits in the input register and is resolved through the
// combinational core into the result register, with the core state updated
// at the same edge; one transaction per cycle is sustained unless m_tready stalls.
// A stall on m_tready holds the result and backs up to s_tready after the
// input register fills. Reset clears the node table and scheduler state at once.
module bus_poll_master_retry #(
    parameter int NODE_COUNT = bpm_pkg::NODE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_us, rx_node, rx_msg_id, rx_len
    input  logic [bpm_pkg::TDATA_IN_W-1:0]   s_tdata,
    // operation, rx_is_ack
    input  logic [bpm_pkg::TUSER_IN_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_node, event_msg_id, round_trip_us, online_count, zero padding
    output logic [bpm_pkg::TDATA_OUT_W-1:0]  m_tdata,
    // handled, event_kind
    output logic [bpm_pkg::TUSER_OUT_W-1:0]  m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpm_pkg::*;

    cfg_t     cfg;
    in_item_t item;
    result_t  result;
    logic     item_valid;
    logic     advance;
    logic     step;

    // An item is resolved when it is present and the result register can load.
    assign step = item_valid && advance;

    bpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bpm_core #(
        .NODE_COUNT (NODE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (item),
        .result (result)
    );

    bpm_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* design/bpm_checker.sv */
// Port-level checks of the polled bus master, bound to the top level.
module bpm_checker #(
    parameter int NODE_COUNT = bpm_pkg::NODE_COUNT_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bpm_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input logic [bpm_pkg::TUSER_OUT_W-1:0]  m_tuser
);
    import bpm_pkg::*;

    // A result that is not taken holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // A step reports work exactly when it reports an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] != EV_NONE)))
    else $error("handled flag disagrees with event kind");

    // Latency is carried by acknowledgements only.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:1] != EV_ACK) |-> (m_tdata[55:24] == 32'd0))
    else $error("latency reported outside an acknowledgement");

    // The online count never exceeds the number of nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[60:56]) <= 32'(NODE_COUNT)))
    else $error("online count above node count");

endmodule

bind bus_poll_master_retry bpm_checker #(
    .NODE_COUNT (NODE_COUNT)
) u_bpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
